@@ src/bad_pkg.sv @@
// Shared types and constants for the binary arithmetic decoder.
// No dependencies; used by bad_step and binary_arithmetic_decoder_unit.
`timescale 1ns / 1ps
`default_nettype none

package bad_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned ProbWidth = 16;
  localparam int unsigned OwedWidth = 3;

  localparam logic [OwedWidth-1:0] MaxOwed = 3'd4;
  localparam logic [WordWidth-1:0] AllOnes = 32'hFFFF_FFFF;
  localparam logic [ProbWidth-1:0] MinProb = 16'd1;

  typedef enum logic {
    KIND_BYTE   = 1'b0,
    KIND_DECODE = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [7:0]           code_byte;
    logic [ProbWidth-1:0] probability;
  } item_t;

  typedef struct packed {
    logic [WordWidth-1:0] low_bound;
    logic [WordWidth-1:0] high_bound;
    logic [WordWidth-1:0] code_value;
    logic [OwedWidth-1:0] owed_bytes;
  } state_t;

  typedef struct packed {
    logic                 decoded_bit;
    logic [OwedWidth-1:0] bytes_wanted;
    logic                 rejected;
  } result_t;

endpackage

`default_nettype wire

@@ src/bad_step.sv @@
// Combinational step of the decoder: one transaction applied to the current state.
// Depends on bad_pkg for the item, state and result types.
`timescale 1ns / 1ps
`default_nettype none

module bad_step (
  input  bad_pkg::item_t   item,
  input  bad_pkg::state_t  state,
  output bad_pkg::state_t  state_next,
  output bad_pkg::result_t result
);
  import bad_pkg::*;

  logic [ProbWidth-1:0] prob;
  logic [WordWidth-1:0] range;
  logic [WordWidth-1:0] prod_hi;
  logic [WordWidth-1:0] prod_lo;
  logic [WordWidth-1:0] xmid;
  logic                 bit_one;
  logic [WordWidth-1:0] low_cut;
  logic [WordWidth-1:0] high_cut;
  logic [WordWidth-1:0] diff;
  logic [OwedWidth-1:0] shifts;
  logic [5:0]           shift_amt;

  assign prob    = (item.probability == '0) ? MinProb : item.probability;
  assign range   = state.high_bound - state.low_bound;
  assign prod_hi = {16'b0, range[31:16]} * {16'b0, prob};
  assign prod_lo = {16'b0, range[15:0]} * {16'b0, prob};
  assign xmid    = state.low_bound + prod_hi + {16'b0, prod_lo[31:16]};
  assign bit_one = (state.code_value <= xmid);

  assign low_cut  = bit_one ? state.low_bound : xmid + 32'd1;
  assign high_cut = bit_one ? xmid : state.high_bound;
  assign diff     = low_cut ^ high_cut;

  // The shift count is the number of leading bytes that the bounds share.
  always_comb begin
    if (diff[31:24] != '0) begin
      shifts = 3'd0;
    end else if (diff[23:16] != '0) begin
      shifts = 3'd1;
    end else if (diff[15:8] != '0) begin
      shifts = 3'd2;
    end else if (diff[7:0] != '0) begin
      shifts = 3'd3;
    end else begin
      shifts = MaxOwed;
    end
  end

  assign shift_amt = {shifts, 3'b000};

  always_comb begin
    state_next         = state;
    result.decoded_bit = 1'b0;
    result.bytes_wanted = state.owed_bytes;
    result.rejected    = 1'b0;
    case (item.kind)
      KIND_BYTE: begin
        if (state.owed_bytes == '0) begin
          result.rejected = 1'b1;
        end else begin
          state_next.code_value = {state.code_value[23:0], item.code_byte};
          state_next.owed_bytes = state.owed_bytes - 3'd1;
          result.bytes_wanted   = state.owed_bytes - 3'd1;
        end
      end
      KIND_DECODE: begin
        if (state.owed_bytes != '0) begin
          result.rejected = 1'b1;
        end else begin
          state_next.low_bound  = low_cut << shift_amt;
          state_next.high_bound = (high_cut << shift_amt) | ~(AllOnes << shift_amt);
          state_next.owed_bytes = shifts;
          result.decoded_bit    = bit_one;
          result.bytes_wanted   = shifts;
        end
      end
      default: begin
        result.rejected = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/binary_arithmetic_decoder_unit.sv @@
// Top level of the carryless 32-bit binary arithmetic decoder.
// Depends on bad_pkg and bad_step.
//
// Usage: each input transaction is either a code byte (kind 0) or a request
// to decode one bit with a 16-bit probability of a one (kind 1). Every input
// transaction yields exactly one output transaction carrying decoded_bit,
// bytes_wanted and rejected, in order.
// Both channels use valid and ready. An accepted transaction lands in an input
// register; when the output register is empty or being taken, the step logic
// applies it to the interval state and loads the output register. One
// transaction is taken per cycle when the receiver keeps up; the rate is set by
// the combinational interval update, which holds two 16x16 multiplies, a 32-bit
// add and compare and the byte shift.
// After reset the interval is [0, 0xFFFFFFFF], the code value is zero, four
// code bytes are owed, and both registers are empty.
// When the receiver stalls, the output register holds its result, the input
// register keeps the next transaction, and in_ready then drops until the
// output is taken.
`timescale 1ns / 1ps
`default_nettype none

module binary_arithmetic_decoder_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [7:0]                    code_byte,
  input  logic [bad_pkg::ProbWidth-1:0] probability,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          decoded_bit,
  output logic [bad_pkg::OwedWidth-1:0] bytes_wanted,
  output logic                          rejected
);
  import bad_pkg::*;

  logic    in_full;
  item_t   in_item;
  state_t  state;
  state_t  state_next;
  result_t step_result;
  result_t out_result;
  logic    advance;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  bad_step u_step (
    .item       (in_item),
    .state      (state),
    .state_next (state_next),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item.kind        <= kind_t'(kind);
      in_item.code_byte   <= code_byte;
      in_item.probability <= probability;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.low_bound  <= '0;
      state.high_bound <= AllOnes;
      state.code_value <= '0;
      state.owed_bytes <= MaxOwed;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign decoded_bit  = out_result.decoded_bit;
  assign bytes_wanted = out_result.bytes_wanted;
  assign rejected     = out_result.rejected;

`ifndef NO_ASSERTIONS
  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    state.low_bound <= state.high_bound)
    else $error("Interval low bound exceeds high bound.");

  a_owed_limit: assert property (@(posedge clk) disable iff (rst)
    state.owed_bytes <= MaxOwed)
    else $error("Owed byte count exceeds four.");

  a_reject_keeps_state: assert property (@(posedge clk) disable iff (rst)
    advance && step_result.rejected |=> $stable(state))
    else $error("A rejected transaction changed the decoder state.");

  a_byte_pays_one: assert property (@(posedge clk) disable iff (rst)
    advance && in_item.kind == KIND_BYTE && !step_result.rejected
    |=> state.owed_bytes == $past(state.owed_bytes) - 3'd1)
    else $error("A code byte did not pay exactly one owed byte.");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(in_item))
    else $error("The input register changed while the output was stalled.");
`endif

endmodule

`default_nettype wire

@@ verif/tb_binary_arithmetic_decoder_unit.sv @@
// Self-checking testbench for binary_arithmetic_decoder_unit, the carryless 32-bit decoder.
// Depends on bad_pkg and the unit; a built-in interval model predicts every output transaction.
`timescale 1ns / 1ps

module tb_binary_arithmetic_decoder_unit;
  import bad_pkg::*;

  localparam int unsigned TargetItems = 850;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 kind = 1'b0;
  logic [7:0]           code_byte = '0;
  logic [ProbWidth-1:0] probability = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 decoded_bit;
  logic [OwedWidth-1:0] bytes_wanted;
  logic                 rejected;

  item_t   code_stream[$];
  result_t decoder_answers[$];
  state_t  model_st;
  logic    in_taken = 1'b0;
  int      stream_len = 0;
  int      n_sent = 0;
  int      n_taken = 0;
  int      n_seen = 0;
  int      n_errors = 0;
  int      n_bits = 0;
  int      n_ones = 0;
  int      n_bytes = 0;
  int      n_rejected = 0;
  int      n_full_shifts = 0;

  binary_arithmetic_decoder_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .code_byte   (code_byte),
    .probability (probability),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .decoded_bit (decoded_bit),
    .bytes_wanted(bytes_wanted),
    .rejected    (rejected)
  );

  always #4 clk = ~clk;

  function automatic state_t interval_reset();
    state_t st;
    st.low_bound  = '0;
    st.high_bound = AllOnes;
    st.code_value = '0;
    st.owed_bytes = MaxOwed;
    return st;
  endfunction

  function automatic result_t arith_decode(inout state_t st, input item_t it);
    result_t              res;
    logic [ProbWidth-1:0] prob;
    logic [WordWidth-1:0] span;
    logic [WordWidth-1:0] split;
    logic [OwedWidth-1:0] shifts;
    res    = '0;
    shifts = '0;
    if (it.kind == KIND_BYTE) begin
      if (st.owed_bytes == '0) begin
        res.rejected = 1'b1;
      end else begin
        st.code_value = {st.code_value[23:0], it.code_byte};
        st.owed_bytes = st.owed_bytes - 3'd1;
      end
    end else if (st.owed_bytes != '0) begin
      res.rejected = 1'b1;
    end else begin
      prob  = (it.probability == '0) ? MinProb : it.probability;
      span  = st.high_bound - st.low_bound;
      split = st.low_bound + {16'd0, span[31:16]} * {16'd0, prob}
              + (({16'd0, span[15:0]} * {16'd0, prob}) >> 16);
      if (st.code_value <= split) begin
        res.decoded_bit = 1'b1;
        st.high_bound   = split;
      end else begin
        st.low_bound = split + 32'd1;
      end
      while (shifts < MaxOwed && st.low_bound[31:24] == st.high_bound[31:24]) begin
        st.low_bound  = {st.low_bound[23:0], 8'h00};
        st.high_bound = {st.high_bound[23:0], 8'hFF};
        shifts        = shifts + 3'd1;
      end
      st.owed_bytes = shifts;
    end
    res.bytes_wanted = st.owed_bytes;
    return res;
  endfunction

  // Stimulus is built up front; a shadow copy of the interval state keeps the
  // random part mostly in order so that decodes get past the byte-owed phase.
  initial begin
    state_t               shadow;
    result_t              res;
    logic [ProbWidth-1:0] prob;
    int                   roll;
    shadow = interval_reset();

    // Decode before any byte, four bytes to fill the code value, then a byte
    // nobody asked for.
    code_stream.push_back('{KIND_DECODE, 8'h5A, 16'h8000});
    code_stream.push_back('{KIND_BYTE, 8'h00, 16'hFFFF});
    code_stream.push_back('{KIND_BYTE, 8'hFF, 16'h0000});
    code_stream.push_back('{KIND_BYTE, 8'hFF, 16'h1234});
    code_stream.push_back('{KIND_BYTE, 8'h01, 16'h0000});
    code_stream.push_back('{KIND_BYTE, 8'hAA, 16'h0001});
    code_stream.push_back('{KIND_DECODE, 8'h00, 16'h00FF});
    code_stream.push_back('{KIND_DECODE, 8'hFF, 16'h0001});
    code_stream.push_back('{KIND_DECODE, 8'h00, 16'h0001});
    code_stream.push_back('{KIND_DECODE, 8'hFF, 16'h0000});
    code_stream.push_back('{KIND_DECODE, 8'h00, 16'hFFFF});
    code_stream.push_back('{KIND_BYTE, 8'hFF, 16'h0000});
    code_stream.push_back('{KIND_BYTE, 8'h00, 16'hFFFF});
    code_stream.push_back('{KIND_BYTE, 8'h80, 16'h0000});
    code_stream.push_back('{KIND_BYTE, 8'h7F, 16'h0000});
    code_stream.push_back('{KIND_DECODE, 8'h00, 16'hFFFF});
    code_stream.push_back('{KIND_DECODE, 8'hFF, 16'h0000});
    code_stream.push_back('{KIND_DECODE, 8'h00, 16'h8000});
    foreach (code_stream[i]) begin
      res = arith_decode(shadow, code_stream[i]);
    end

    while (code_stream.size() < TargetItems) begin
      roll = $urandom_range(99);
      case ($urandom_range(9))
        0:       prob = '0;
        1:       prob = MinProb;
        2:       prob = 16'hFFFF;
        3:       prob = 16'($urandom_range(255));
        4:       prob = 16'($urandom_range(65535, 65280));
        default: prob = 16'($urandom_range(65535));
      endcase
      if ((shadow.owed_bytes != '0) == (roll < 92)) begin
        code_stream.push_back('{KIND_BYTE, 8'($urandom_range(255)), prob});
      end else begin
        code_stream.push_back('{KIND_DECODE, 8'($urandom_range(255)), prob});
      end
      res = arith_decode(shadow, code_stream[$]);
    end
    stream_len = code_stream.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Sender gaps: 14 percent, then 50 percent, then none.
  always @(negedge clk) begin
    int   gap_pct;
    int   phase;
    item_t it;
    phase   = (stream_len == 0) ? 0 : (n_sent * 3) / stream_len;
    gap_pct = (phase == 0) ? 14 : (phase == 1) ? 50 : 0;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (code_stream.size() != 0 && $urandom_range(99) >= gap_pct) begin
        it = code_stream.pop_front();
        kind        <= it.kind;
        code_byte   <= it.code_byte;
        probability <= it.probability;
        in_valid    <= 1'b1;
        n_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls: 50 percent, then 14 percent, then none.
  always @(negedge clk) begin
    int stall_pct;
    int phase;
    phase     = (stream_len == 0) ? 0 : (n_seen * 3) / stream_len;
    stall_pct = (phase == 0) ? 50 : (phase == 1) ? 14 : 0;
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    result_t want;
    item_t   got_item;
    if (rst) begin
      model_st = interval_reset();
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        got_item = '{kind_t'(kind), code_byte, probability};
        if (got_item.kind == KIND_BYTE) begin
          n_bytes++;
        end else if (model_st.owed_bytes == '0) begin
          n_bits++;
        end
        decoder_answers.push_back(arith_decode(model_st, got_item));
        n_taken++;
      end
      if (out_valid && out_ready) begin
        n_seen++;
        if (decoder_answers.size() == 0) begin
          $error("output transaction with no prediction pending");
          n_errors++;
        end else begin
          want = decoder_answers.pop_front();
          if (decoded_bit !== want.decoded_bit) begin
            $error("decoded_bit: expected %0d, got %0d", want.decoded_bit, decoded_bit);
            n_errors++;
          end
          if (bytes_wanted !== want.bytes_wanted) begin
            $error("bytes_wanted: expected %0d, got %0d", want.bytes_wanted, bytes_wanted);
            n_errors++;
          end
          if (rejected !== want.rejected) begin
            $error("rejected: expected %0d, got %0d", want.rejected, rejected);
            n_errors++;
          end
          if (want.rejected) begin
            n_rejected++;
          end else begin
            if (want.decoded_bit) begin
              n_ones++;
            end
            if (want.bytes_wanted == MaxOwed) begin
              n_full_shifts++;
            end
          end
        end
      end
    end
  end

  initial begin
    wait (!rst);
    while (n_taken < stream_len) @(posedge clk);
    while (decoder_answers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Run covered %0d transactions: %0d decodes (%0d ones), %0d code bytes,",
             n_taken, n_bits, n_ones, n_bytes);
    $display("%0d four-byte shifts, %0d out-of-order transactions rejected, %0d mismatches.",
             n_full_shifts, n_rejected, n_errors);
    if (n_errors == 0) begin
      $display("tb_binary_arithmetic_decoder_unit passed");
    end else begin
      $display("tb_binary_arithmetic_decoder_unit failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_binary_arithmetic_decoder_unit failed");
    $finish;
  end

endmodule
